// ----- rtl/core/brr_pkg.sv -----
// shared types and constants of the brr block decoder
// no dependencies; used by every module under rtl/core
package brr_pkg;

  localparam int unsigned SampleW   = 17;
  localparam int unsigned CalcW     = 22;
  localparam logic [3:0]  RangeMax  = 4'd12;
  localparam logic [3:0]  BlockLen  = 4'd8;
  localparam logic        CfgIdxWrap = 1'b0;

  typedef enum logic [1:0] {
    FiltNone  = 2'd0,
    FiltOne   = 2'd1,
    FiltTwo   = 2'd2,
    FiltThree = 2'd3
  } brr_filt_e;

  // fields of the current block header
  typedef struct packed {
    logic [3:0] shift_range;
    brr_filt_e  filter_sel;
    logic       loop_flag;
    logic       end_flag;
  } brr_hdr_t;

endpackage

// ----- rtl/core/brr_cfg_regs.sv -----
// apb register file of the brr block decoder: wrap_history at byte address 0
// depends on brr_pkg
module brr_cfg_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        wrap_o
);

  logic wrap_q, wrap_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    wrap_d = wrap_q;
    if (wr_en && (paddr[2] == brr_pkg::CfgIdxWrap)) begin
      wrap_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b0;
    end else begin
      wrap_q <= wrap_d;
    end
  end

  // low address bits ignored, word aligned access assumed
  assign prdata = (paddr[2] == brr_pkg::CfgIdxWrap) ? {31'd0, wrap_q} : 32'd0;
  assign wrap_o = wrap_q;

endmodule

// ----- rtl/core/brr_nibble_dec.sv -----
// one brr nibble to one doubled sample: range scaling, prediction filter, clamp
// depends on brr_pkg
module brr_nibble_dec (
  input  logic                                 wrap_i,
  input  brr_pkg::brr_hdr_t                    hdr_i,
  input  logic [3:0]                           nibble_i,
  input  logic signed [brr_pkg::SampleW-1:0]   prev_i,
  input  logic signed [brr_pkg::SampleW-1:0]   prev_prev_i,
  output logic signed [brr_pkg::SampleW-1:0]   sample_o
);

  logic signed [brr_pkg::CalcW-1:0] a1, a2, a1x13, nib_ext, scaled, pred, sum;
  logic signed [15:0]               clamped;
  logic signed [16:0]               doubled;

  always_comb begin
    a1      = brr_pkg::CalcW'(prev_i);
    a2      = brr_pkg::CalcW'(prev_prev_i);
    nib_ext = brr_pkg::CalcW'(signed'(nibble_i));
    a1x13   = (a1 <<< 3) + (a1 <<< 2) + a1;

    if (hdr_i.shift_range <= brr_pkg::RangeMax) begin
      scaled = (nib_ext <<< hdr_i.shift_range) >>> 1;
    end else begin
      scaled = nibble_i[3] ? -22'sd2048 : 22'sd0;
    end

    unique case (hdr_i.filter_sel)
      brr_pkg::FiltOne:   pred = (a1 >>> 1) + ((-a1) >>> 5);
      brr_pkg::FiltTwo:   pred = a1 + ((-(a1 + (a1 >>> 1))) >>> 5)
                                 - (a2 >>> 1) + (a2 >>> 5);
      brr_pkg::FiltThree: pred = a1 + ((-a1x13) >>> 7)
                                 - (a2 >>> 1) + ((a2 + (a2 >>> 1)) >>> 4);
      default:            pred = '0;
    endcase

    sum = scaled + pred;

    if (sum < -22'sd32768) begin
      clamped = 16'sh8000;
    end else if (sum > 22'sd32767) begin
      clamped = 16'sh7fff;
    end else begin
      clamped = sum[15:0];
    end

    doubled = {clamped, 1'b0};
    // new mode drops the top bit and sign extends from bit 15
    sample_o = wrap_i ? {doubled[15], doubled[15:0]} : doubled;
  end

endmodule

// ----- rtl/core/brr_adpcm_block_decoder.sv -----
// top level of the brr block decoder: stream ports, byte holding stage,
// history registers and output register; uses brr_pkg, brr_cfg_regs, brr_nibble_dec
// A header byte gives no item; a data byte gives two items, high nibble
// first, and brr_nibble_dec makes one sample per cycle while the output
// register is free; each sample feeds the history for the next one.
// The next byte is accepted in the cycle that decodes the low nibble. A result
// waiting in the output register stalls decoding until it is taken, so
// m_axis_tready reaches s_axis_tready in the same cycle. restart
// (tuser) forces a header and keeps the history; configuration is to be
// written over apb only while the block is idle, which the block does not enforce.
module brr_adpcm_block_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] restart
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [16:0] sample, [23:17] zero
  output logic [1:0]  m_axis_tuser,   // [0] block_end, [1] block_loop
  output logic        m_axis_tlast    // last
);

  logic wrap;

  brr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .wrap_o  (wrap)
  );

  brr_pkg::brr_hdr_t hdr_q, hdr_d;
  logic [3:0]        left_q, left_d;
  logic              hold_vld_q, hold_vld_d;
  logic [7:0]        hold_byte_q, hold_byte_d;
  logic              phase_q, phase_d;
  logic signed [brr_pkg::SampleW-1:0] prev_q, prev_d, prev2_q, prev2_d;
  logic              out_vld_q, out_vld_d;
  logic signed [brr_pkg::SampleW-1:0] out_smp_q, out_smp_d;
  logic [1:0]        out_flags_q, out_flags_d;
  logic              out_last_q, out_last_d;

  logic out_free, dec_go, accept, is_hdr;
  logic [3:0] nibble;
  logic signed [brr_pkg::SampleW-1:0] dec_sample;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign dec_go        = hold_vld_q && out_free;
  assign s_axis_tready = !hold_vld_q || (phase_q && dec_go);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_hdr        = s_axis_tuser || (left_q == 4'd0);
  assign nibble        = phase_q ? hold_byte_q[3:0] : hold_byte_q[7:4];

  brr_nibble_dec u_dec (
    .wrap_i      (wrap),
    .hdr_i       (hdr_q),
    .nibble_i    (nibble),
    .prev_i      (prev_q),
    .prev_prev_i (prev2_q),
    .sample_o    (dec_sample)
  );

  always_comb begin
    hdr_d       = hdr_q;
    left_d      = left_q;
    hold_vld_d  = hold_vld_q;
    hold_byte_d = hold_byte_q;
    phase_d     = phase_q;
    prev_d      = prev_q;
    prev2_d     = prev2_q;
    out_vld_d   = out_vld_q;
    out_smp_d   = out_smp_q;
    out_flags_d = out_flags_q;
    out_last_d  = out_last_q;

    if (dec_go) begin
      prev2_d     = prev_q;
      prev_d      = dec_sample;
      out_vld_d   = 1'b1;
      out_smp_d   = dec_sample;
      out_flags_d = {hdr_q.loop_flag, hdr_q.end_flag};
      out_last_d  = phase_q;
      if (phase_q) begin
        hold_vld_d = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    // header fields change only once the held byte is done with them
    if (accept) begin
      if (is_hdr) begin
        hdr_d  = brr_pkg::brr_hdr_t'(s_axis_tdata);
        left_d = brr_pkg::BlockLen;
      end else begin
        left_d      = left_q - 4'd1;
        hold_vld_d  = 1'b1;
        hold_byte_d = s_axis_tdata;
        phase_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q      <= '0;
      left_q     <= 4'd0;
      hold_vld_q <= 1'b0;
      phase_q    <= 1'b0;
      prev_q     <= '0;
      prev2_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      hdr_q      <= hdr_d;
      left_q     <= left_d;
      hold_vld_q <= hold_vld_d;
      phase_q    <= phase_d;
      prev_q     <= prev_d;
      prev2_q    <= prev2_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_byte_q <= hold_byte_d;
    out_smp_q   <= out_smp_d;
    out_flags_q <= out_flags_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_smp_q};
  assign m_axis_tuser  = out_flags_q;
  assign m_axis_tlast  = out_last_q;

endmodule
